// File: design/ucv_pkg.sv
// Shared types and byte constants for the UTF-8 name component validator.
`timescale 1ns / 1ps

package ucv_pkg;

    localparam int unsigned BYTE_W = 8;

    localparam logic [BYTE_W-1:0] CTRL_LIMIT = 8'h20;
    localparam logic [BYTE_W-1:0] DEL_BYTE   = 8'h7f;
    localparam logic [BYTE_W-1:0] BSLASH     = 8'h5c;
    localparam logic [BYTE_W-1:0] ASCII_TOP  = 8'h80;
    localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hc0;
    localparam logic [BYTE_W-1:0] CONT_LO    = 8'h80;
    localparam logic [BYTE_W-1:0] CONT_HI    = 8'hbf;
    localparam logic [BYTE_W-1:0] LEAD2_LO   = 8'hc2;
    localparam logic [BYTE_W-1:0] LEAD2_HI   = 8'hdf;
    localparam logic [BYTE_W-1:0] LEAD3_LO   = 8'he0;
    localparam logic [BYTE_W-1:0] LEAD3_HI   = 8'hef;
    localparam logic [BYTE_W-1:0] LEAD_ED    = 8'hed;
    localparam logic [BYTE_W-1:0] LEAD4_LO   = 8'hf0;
    localparam logic [BYTE_W-1:0] LEAD4_HI   = 8'hf4;
    localparam logic [BYTE_W-1:0] E0_CONT_LO = 8'ha0;
    localparam logic [BYTE_W-1:0] ED_CONT_HI = 8'h9f;
    localparam logic [BYTE_W-1:0] F0_CONT_LO = 8'h90;
    localparam logic [BYTE_W-1:0] F4_CONT_HI = 8'h8f;

    localparam logic [1:0] PEND_NONE = 2'd0;
    localparam logic [1:0] PEND_ONE  = 2'd1;
    localparam logic [1:0] PEND_TWO  = 2'd2;
    localparam logic [1:0] PEND_THREE = 2'd3;

    // Allowed range of the first continuation byte after a lead byte.
    typedef enum logic [2:0] {
        RNG_ANY = 3'd0,
        RNG_E0  = 3'd1,
        RNG_ED  = 3'd2,
        RNG_F0  = 3'd3,
        RNG_F4  = 3'd4
    } rng_t;

    // Classified beat as it travels from the front end to the checker.
    typedef struct packed {
        logic       cont_any;
        logic       cont_e0;
        logic       cont_ed;
        logic       cont_f0;
        logic       cont_f4;
        logic       lead_bad;
        logic [1:0] lead_pend;
        rng_t       lead_rng;
        logic       last;
    } cls_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

// File: design/ucv_classify.sv
// Front end: classify one input byte as lead or continuation.
`timescale 1ns / 1ps

module ucv_classify (
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output ucv_pkg::cls_t cls
);
    import ucv_pkg::*;

    logic is_cont;

    assign is_cont = (data_byte & CONT_MASK) == CONT_LO;

    always_comb begin
        cls           = '0;
        cls.last      = last_byte;
        cls.cont_any  = is_cont;
        cls.cont_e0   = data_byte >= E0_CONT_LO && data_byte <= CONT_HI;
        cls.cont_ed   = data_byte >= CONT_LO && data_byte <= ED_CONT_HI;
        cls.cont_f0   = data_byte >= F0_CONT_LO && data_byte <= CONT_HI;
        cls.cont_f4   = data_byte >= CONT_LO && data_byte <= F4_CONT_HI;
        cls.lead_pend = PEND_NONE;
        cls.lead_rng  = RNG_ANY;
        cls.lead_bad  = 1'b0;
        priority if (data_byte < CTRL_LIMIT || data_byte == DEL_BYTE
                     || data_byte == BSLASH) begin
            cls.lead_bad = 1'b1;
        end else if (data_byte < ASCII_TOP) begin
            cls.lead_pend = PEND_NONE;
        end else if (data_byte >= LEAD2_LO && data_byte <= LEAD2_HI) begin
            cls.lead_pend = PEND_ONE;
        end else if (data_byte >= LEAD3_LO && data_byte <= LEAD3_HI) begin
            cls.lead_pend = PEND_TWO;
            if (data_byte == LEAD3_LO) begin
                cls.lead_rng = RNG_E0;
            end else if (data_byte == LEAD_ED) begin
                cls.lead_rng = RNG_ED;
            end
        end else if (data_byte >= LEAD4_LO && data_byte <= LEAD4_HI) begin
            cls.lead_pend = PEND_THREE;
            if (data_byte == LEAD4_LO) begin
                cls.lead_rng = RNG_F0;
            end else if (data_byte == LEAD4_HI) begin
                cls.lead_rng = RNG_F4;
            end
        end else begin
            cls.lead_bad = 1'b1;
        end
    end

endmodule

// File: design/ucv_queue.sv
// Two-entry queue of classified beats between front end and checker.
`timescale 1ns / 1ps

module ucv_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  ucv_pkg::cls_t   push_data,
    input  logic            pop,
    output ucv_pkg::cls_t   head,
    output ucv_pkg::q_stat_t stat
);
    import ucv_pkg::*;

    localparam int unsigned DEPTH = 2;
    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    cls_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign stat.full  = count_reg == CNT_W'(DEPTH);
    assign stat.empty = count_reg == '0;
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head       = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = CNT_W'(count_reg + 1'b1);
        end else if (do_pop && !do_push) begin
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: design/ucv_check.sv
// Back end: sequence state, sticky failure and verdict output register.
`timescale 1ns / 1ps

module ucv_check (
    input  logic          aclk,
    input  logic          aresetn,
    input  ucv_pkg::cls_t head,
    input  logic          head_valid,
    output logic          pop,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic          verdict
);
    import ucv_pkg::*;

    logic [1:0] pend_reg, pend_next;
    rng_t       rng_reg, rng_next;
    logic       failed_reg, failed_next;
    logic       out_valid_reg, out_valid_next;
    logic       verdict_reg, verdict_next;
    logic       out_free, cont_ok;

    assign out_free = !out_valid_reg || m_tready;
    // Hold a last beat in the queue until the output slot frees up.
    assign pop      = head_valid && (!head.last || out_free);
    assign m_tvalid = out_valid_reg;
    assign verdict  = verdict_reg;

    always_comb begin
        unique case (rng_reg)
            RNG_E0:  cont_ok = head.cont_e0;
            RNG_ED:  cont_ok = head.cont_ed;
            RNG_F0:  cont_ok = head.cont_f0;
            RNG_F4:  cont_ok = head.cont_f4;
            default: cont_ok = head.cont_any;
        endcase
    end

    always_comb begin
        pend_next      = pend_reg;
        rng_next       = rng_reg;
        failed_next    = failed_reg;
        out_valid_next = out_valid_reg && !m_tready;
        verdict_next   = verdict_reg;
        if (pop) begin
            if (pend_reg != PEND_NONE) begin
                rng_next = RNG_ANY;
                if (cont_ok) begin
                    pend_next = 2'(pend_reg - 1'b1);
                end else begin
                    failed_next = 1'b1;
                    pend_next   = PEND_NONE;
                end
            end else begin
                rng_next = head.lead_rng;
                if (head.lead_bad) begin
                    failed_next = 1'b1;
                end else begin
                    pend_next = head.lead_pend;
                end
            end
            if (head.last) begin
                out_valid_next = 1'b1;
                verdict_next   = !failed_next && pend_next == PEND_NONE;
                pend_next      = PEND_NONE;
                rng_next       = RNG_ANY;
                failed_next    = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg      <= PEND_NONE;
            rng_reg       <= RNG_ANY;
            failed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            pend_reg      <= pend_next;
            rng_reg       <= rng_next;
            failed_reg    <= failed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        verdict_reg <= verdict_next;
    end

endmodule

// File: design/utf8_name_component_validator_unit.sv
// Top level of the streaming UTF-8 file-name component validator.
`timescale 1ns / 1ps

// Usage:
// - Slave channel (s_): one byte of a name component per beat; s_tlast marks
//   the final byte of the component.
// - Master channel (m_): one beat per component, sent after its last byte;
//   m_tdata[0] is 1 when the component is strict UTF-8 with no control byte,
//   DEL or backslash and no sequence left open, else 0.
// - Throughput: one byte per cycle, sustained, while the receiver keeps up.
//   Each byte costs one update of the sequence state in the checker.
// - Path of a last byte: it is classified and written into the queue; the
//   checker then pops it and registers its verdict once the output slot frees.
// - A two-beat queue sits between the classifier and the checker. When the
//   receiver stalls, the checker keeps consuming non-last bytes and holds a
//   last byte in the queue until the verdict register frees; s_tready drops
//   only when the queue is full.
// - Reset (aresetn low at a clock edge) empties the queue, drops any pending
//   verdict and returns the sequence state to its idle value.
module utf8_name_component_validator_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,   // last_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [0] component_valid, [7:1] zero
);
    import ucv_pkg::*;

    cls_t    cls;
    cls_t    head;
    q_stat_t q_stat;
    logic    pop;
    logic    verdict;

    // Classify on the way in; the queue stores the classified beat.
    ucv_classify u_classify (
        .data_byte (s_tdata),
        .last_byte (s_tlast),
        .cls       (cls)
    );

    ucv_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_tvalid),
        .push_data (cls),
        .pop       (pop),
        .head      (head),
        .stat      (q_stat)
    );

    // Advance sequence state and register the verdict.
    ucv_check u_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (head),
        .head_valid (!q_stat.empty),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .verdict    (verdict)
    );

    assign s_tready = !q_stat.full;
    assign m_tdata  = {7'b0, verdict};

`ifndef SYNTHESIS
    a_queue_status: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_stat.full && q_stat.empty))
        else $error("queue reports full and empty at once");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && q_stat.empty)
        else $error("reset left a verdict or queued beat");

    a_push_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !q_stat.empty)
        else $error("accepted beat missing from queue");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_stat.empty)
        else $error("checker popped an empty queue");
`endif

endmodule
